[design/okumura_hata_path_loss_macros.svh]
// assertion macros for the okumura-hata path loss block
// used by the top level only, needs signals clock and reset in scope
`ifndef OKUMURA_HATA_PATH_LOSS_MACROS_SVH
`define OKUMURA_HATA_PATH_LOSS_MACROS_SVH
`ifndef ASSERT_OFF
`define OHPL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ohpl assertion failed");
`define OHPL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ohpl implication failed");
`else
`define OHPL_ASSERT(label, prop)
`define OHPL_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

[design/ohpl_pkg.sv]
// shared types, constants and fixed-point helpers for the path loss block
// no dependencies
package ohpl_pkg;

   localparam int CARRIER_W  = 11;
   localparam int BASE_W     = 12;
   localparam int MOBILE_W   = 8;
   localparam int ENV_W      = 3;
   localparam int DIST_W     = 13;
   localparam int LOSS_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam int LOG_STEPS = 16;
   // normalise, squaring steps, scale multiply, rounding
   localparam int LOG_LAT   = LOG_STEPS + 3;

   localparam int CARRIER_SHIFT = 0;
   localparam int HEIGHT_SHIFT  = 4;
   localparam int DIST_SHIFT    = 8;

   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] wide_type;

   typedef enum logic [ENV_W-1:0] {
      ENV_IDLE     = 3'd0,
      ENV_METRO    = 3'd1,
      ENV_CITY     = 3'd2,
      ENV_SUBURBAN = 3'd3,
      ENV_RURAL    = 3'd4
   } env_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CARRIER = 2'd0,
      CSR_BASE    = 2'd1,
      CSR_MOBILE  = 2'd2,
      CSR_ENV     = 2'd3
   } csr_idx_type;

   localparam logic [CARRIER_W-1:0] CARRIER_RST = 11'd1500;
   localparam logic [BASE_W-1:0]    BASE_RST    = 12'd3200;
   localparam logic [MOBILE_W-1:0]  MOBILE_RST  = 8'd160;
   localparam logic [ENV_W-1:0]     ENV_RST     = ENV_IDLE;

   localparam logic [CARRIER_W-1:0] METRO_LOW_MHZ  = 11'd200;
   localparam logic [CARRIER_W-1:0] METRO_HIGH_MHZ = 11'd400;

   localparam q_type LOG10_2_Q30 = 32'sd323228497;
   localparam q_type C_69_55  = 32'sd4558029;
   localparam q_type C_26_16  = 32'sd1714422;
   localparam q_type C_13_82  = 32'sd905708;
   localparam q_type C_44_90  = 32'sd2942566;
   localparam q_type C_6_55   = 32'sd429261;
   localparam q_type C_8_29   = 32'sd543293;
   localparam q_type C_1_1    = 32'sd72090;
   localparam q_type C_3_2    = 32'sd209715;
   localparam q_type C_4_97   = 32'sd325714;
   localparam q_type C_0_7    = 32'sd45875;
   localparam q_type C_1_56   = 32'sd102236;
   localparam q_type C_0_8    = 32'sd52429;
   localparam q_type C_2      = 32'sd131072;
   localparam q_type C_5_4    = 32'sd353894;
   localparam q_type C_4_78   = 32'sd313262;
   localparam q_type C_18_33  = 32'sd1201275;
   localparam q_type C_40_98  = 32'sd2685665;
   localparam q_type LG_1_54  = 32'sd12289;
   localparam q_type LG_11_75 = 32'sd70126;
   localparam q_type LG_28    = 32'sd94841;

   // round to nearest, halves away from zero
   function automatic wide_type rnd_shift(input wide_type v, input int unsigned k);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] r;
      half = 64'd1 << (k - 1);
      mag  = v[63] ? 64'(-v) : 64'(v);
      r    = (mag + half) >> k;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic q_type mul_q16(input q_type a, input q_type b);
      wide_type p;
      p = a * b;
      return q_type'(rnd_shift(p, 16));
   endfunction

endpackage

[design/ohpl_log10.sv]
// pipelined log10 of an unsigned integer scaled by 2^-SHIFT, result in Q16
// depends on ohpl_pkg; the pipeline advances only while enable is high
module ohpl_log10 #(
   parameter int XW    = ohpl_pkg::DIST_W,
   parameter int SHIFT = ohpl_pkg::DIST_SHIFT
) (
   input  logic            clock,
   input  logic            enable,
   input  logic [XW-1:0]   x,
   output ohpl_pkg::q_type log_q
);

   localparam int NW    = (XW > 1) ? $clog2(XW) : 1;
   localparam int STEPS = ohpl_pkg::LOG_STEPS;

   logic [XW-1:0]    xz;
   logic [NW-1:0]    n_in;
   logic [31:0]      m_in;

   logic [31:0]      m_ff    [0:STEPS];
   logic [NW-1:0]    n_ff    [0:STEPS];
   logic [STEPS-1:0] frac_ff [0:STEPS];

   ohpl_pkg::q_type    l2_in;
   ohpl_pkg::wide_type prod_in;
   ohpl_pkg::wide_type prod_ff;
   ohpl_pkg::q_type    log_ff;

   // leading one search, zero taken as one
   always_comb begin
      xz   = (x == '0) ? XW'(1) : x;
      n_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (xz[i]) begin
            n_in = NW'(i);
         end
      end
      m_in = 32'(xz) << (6'd31 - 6'(n_in));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff[0]    <= m_in;
         n_ff[0]    <= n_in;
         frac_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic [63:0] sq;
      logic [32:0] sh;
      always_comb begin
         sq = m_ff[g] * m_ff[g];
         sh = sq[63:31];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            m_ff[g+1]    <= sh[32] ? sh[32:1] : sh[31:0];
            n_ff[g+1]    <= n_ff[g];
            frac_ff[g+1] <= {frac_ff[g][STEPS-2:0], sh[32]};
         end
      end
   end

   always_comb begin
      l2_in   = ohpl_pkg::q_type'({n_ff[STEPS], frac_ff[STEPS]})
              - ohpl_pkg::q_type'(SHIFT << STEPS);
      prod_in = l2_in * ohpl_pkg::LOG10_2_Q30;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         log_ff  <= ohpl_pkg::q_type'(ohpl_pkg::rnd_shift(prod_ff, 30));
      end
   end

   assign log_q = log_ff;

endmodule

[design/okumura_hata_path_loss.sv]
// okumura-hata median path loss, one distance in, one loss out
// depends on ohpl_pkg, ohpl_log10 and okumura_hata_path_loss_macros.svh
//
//  channel   direction  payload                       handshake
//  req_      in         tdata[12:0] distance          tvalid / tready
//  rsp_      out        tdata[15:0] path_loss         tvalid / tready
//  csr_      in         index, wdata (12 bit)         wr_en, no back-pressure
//
// one item per cycle unless the output stalls; the path runs through the log10
// units (16 squaring stages), three arithmetic stages and the output register.
// synchronous reset clears valid bits and loads the configuration defaults.
// a stalled output freezes the whole pipeline; no item is lost or repeated.
`include "okumura_hata_path_loss_macros.svh"
module okumura_hata_path_loss (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [12:0] distance, [15:13] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] path_loss
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int VLD_N = ohpl_pkg::LOG_LAT + 3;

   logic [ohpl_pkg::CARRIER_W-1:0] carrier_ff;
   logic [ohpl_pkg::BASE_W-1:0]    base_ff;
   logic [ohpl_pkg::MOBILE_W-1:0]  mobile_ff;
   logic [ohpl_pkg::ENV_W-1:0]     env_ff;

   logic             adv;
   logic [VLD_N-1:0] vld_ff;
   logic             rsp_valid_ff;
   logic [ohpl_pkg::LOSS_W-1:0] rsp_data_ff;
   logic [ohpl_pkg::LOSS_W-1:0] rsp_data_in;

   ohpl_pkg::q_type lf, lh, lm, ld;
   logic            f_low, f_high;

   // stage a
   ohpl_pkg::q_type lsel, l28;
   ohpl_pkg::q_type p26_ff, p1382_ff, p655_ff, p11_ff, p156_ff;
   ohpl_pkg::q_type lff_ff, p1833_ff, l28sq_ff, lmsq_ff, ld_ff;
   // stage b
   ohpl_pkg::wide_type t_wide;
   ohpl_pkg::q_type sld_ff, t_ff, metro_ff, rur_ff, sub_ff;
   ohpl_pkg::q_type p26_b_ff, p1382_b_ff, p156_b_ff, p1833_b_ff;
   // stage c
   ohpl_pkg::q_type a_med, a_in, c_in;
   ohpl_pkg::q_type base_sum_ff, corr_ff;
   // output
   ohpl_pkg::q_type    total;
   ohpl_pkg::wide_type q8;

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff <= ohpl_pkg::CARRIER_RST;
         base_ff    <= ohpl_pkg::BASE_RST;
         mobile_ff  <= ohpl_pkg::MOBILE_RST;
         env_ff     <= ohpl_pkg::ENV_RST;
      end else if (csr_wr_en) begin
         case (ohpl_pkg::csr_idx_type'(csr_index))
            ohpl_pkg::CSR_CARRIER: carrier_ff <= csr_wdata[ohpl_pkg::CARRIER_W-1:0];
            ohpl_pkg::CSR_BASE:    base_ff    <= csr_wdata[ohpl_pkg::BASE_W-1:0];
            ohpl_pkg::CSR_MOBILE:  mobile_ff  <= csr_wdata[ohpl_pkg::MOBILE_W-1:0];
            ohpl_pkg::CSR_ENV:     env_ff     <= csr_wdata[ohpl_pkg::ENV_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VLD_N-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[VLD_N-1];
      end
   end

   // cfg lanes track distance; user must change config only when idle, unchecked
   ohpl_log10 #(.XW(ohpl_pkg::CARRIER_W), .SHIFT(ohpl_pkg::CARRIER_SHIFT)) u_log_f (
      .clock(clock), .enable(adv), .x(carrier_ff), .log_q(lf));
   ohpl_log10 #(.XW(ohpl_pkg::BASE_W), .SHIFT(ohpl_pkg::HEIGHT_SHIFT)) u_log_hb (
      .clock(clock), .enable(adv), .x(base_ff), .log_q(lh));
   ohpl_log10 #(.XW(ohpl_pkg::MOBILE_W), .SHIFT(ohpl_pkg::HEIGHT_SHIFT)) u_log_hm (
      .clock(clock), .enable(adv), .x(mobile_ff), .log_q(lm));
   ohpl_log10 #(.XW(ohpl_pkg::DIST_W), .SHIFT(ohpl_pkg::DIST_SHIFT)) u_log_d (
      .clock(clock), .enable(adv), .x(req_tdata[ohpl_pkg::DIST_W-1:0]), .log_q(ld));

   assign f_low  = carrier_ff <= ohpl_pkg::METRO_LOW_MHZ;
   assign f_high = carrier_ff >= ohpl_pkg::METRO_HIGH_MHZ;

   // stage a: first products of the logarithms
   always_comb begin
      lsel = lm + (f_low ? ohpl_pkg::LG_1_54 : ohpl_pkg::LG_11_75);
      l28  = lf - ohpl_pkg::LG_28;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p26_ff   <= ohpl_pkg::mul_q16(ohpl_pkg::C_26_16, lf);
         p1382_ff <= ohpl_pkg::mul_q16(ohpl_pkg::C_13_82, lh);
         p655_ff  <= ohpl_pkg::mul_q16(ohpl_pkg::C_6_55, lh);
         p11_ff   <= ohpl_pkg::mul_q16(ohpl_pkg::C_1_1, lf);
         p156_ff  <= ohpl_pkg::mul_q16(ohpl_pkg::C_1_56, lf);
         lff_ff   <= ohpl_pkg::mul_q16(lf, lf);
         p1833_ff <= ohpl_pkg::mul_q16(ohpl_pkg::C_18_33, lf);
         l28sq_ff <= ohpl_pkg::mul_q16(l28, l28);
         lmsq_ff  <= ohpl_pkg::mul_q16(lsel, lsel);
         ld_ff    <= ld;
      end
   end

   // stage b: second products
   always_comb begin
      t_wide = (p11_ff - ohpl_pkg::C_0_7) * ohpl_pkg::q_type'(mobile_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sld_ff     <= ohpl_pkg::mul_q16(ohpl_pkg::C_44_90 - p655_ff, ld_ff);
         t_ff       <= ohpl_pkg::q_type'(ohpl_pkg::rnd_shift(t_wide, 4));
         metro_ff   <= ohpl_pkg::mul_q16(f_low ? ohpl_pkg::C_8_29 : ohpl_pkg::C_3_2,
                                         lmsq_ff);
         rur_ff     <= ohpl_pkg::mul_q16(ohpl_pkg::C_4_78, lff_ff);
         sub_ff     <= ohpl_pkg::mul_q16(ohpl_pkg::C_2, l28sq_ff);
         p26_b_ff   <= p26_ff;
         p1382_b_ff <= p1382_ff;
         p156_b_ff  <= p156_ff;
         p1833_b_ff <= p1833_ff;
      end
   end

   // stage c: pick the corrections for the environment and sum the base terms
   always_comb begin
      a_med = t_ff - (p156_b_ff - ohpl_pkg::C_0_8);
      a_in  = '0;
      c_in  = '0;
      case (ohpl_pkg::env_type'(env_ff))
         ohpl_pkg::ENV_METRO: begin
            if (f_low) begin
               a_in = metro_ff - ohpl_pkg::C_1_1;
            end else if (f_high) begin
               a_in = metro_ff - ohpl_pkg::C_4_97;
            end else begin
               a_in = a_med;
            end
         end
         ohpl_pkg::ENV_CITY: begin
            a_in = a_med;
         end
         ohpl_pkg::ENV_SUBURBAN: begin
            a_in = a_med;
            c_in = -sub_ff - ohpl_pkg::C_5_4;
         end
         ohpl_pkg::ENV_RURAL: begin
            a_in = a_med;
            c_in = -rur_ff + p1833_b_ff - ohpl_pkg::C_40_98;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         base_sum_ff <= ohpl_pkg::C_69_55 + p26_b_ff - p1382_b_ff + sld_ff;
         corr_ff     <= c_in - a_in;
      end
   end

   // output: round to 1/256 db and saturate
   always_comb begin
      total = base_sum_ff + corr_ff;
      q8    = ohpl_pkg::rnd_shift(ohpl_pkg::wide_type'(total), 8);
      if (q8 < 0) begin
         rsp_data_in = '0;
      end else if (q8 > 64'sd65535) begin
         rsp_data_in = '1;
      end else begin
         rsp_data_in = q8[ohpl_pkg::LOSS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `OHPL_ASSERT_IMPLY(a_stall_blocks_input, rsp_tvalid && !rsp_tready, !req_tready)
   `OHPL_ASSERT(a_valid_held_on_stall, !adv |=> $stable(vld_ff))
   `OHPL_ASSERT(a_result_from_pipe, $rose(rsp_tvalid) |-> $past(vld_ff[VLD_N-1]))

endmodule
